// ===== rtl/core/lis_pkg.sv =====
// Shared constants, command codes and status types for the LIS tracker.
`timescale 1ns / 1ps

package lis_pkg;

    // Field widths of the two channels.
    localparam int VAL_W = 10;
    localparam int OUT_W = 16;

    // Defaults for the top-level parameters.
    localparam int DEF_TREE_SIZE = 1024;
    localparam int DEF_LEN_BITS  = 16;

    // Command codes carried by s_cmd.
    typedef enum logic [0:0] {
        CMD_PUSH  = 1'b0,
        CMD_CLEAR = 1'b1
    } lis_cmd_t;

    // Status of the back end, watched at the top level.
    typedef struct packed {
        logic sweep;
        logic idle;
        logic result;
    } lis_stat_t;

endpackage

// ===== rtl/core/lis_front.sv =====
// Front end: accepts transactions, classifies and clamps them, and queues them.
`timescale 1ns / 1ps

module lis_front #(
    parameter int TREE_SIZE = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_cmd,
    input  logic [lis_pkg::VAL_W-1:0]         s_value,
    output logic                              q_valid,
    input  logic                              q_ready,
    output logic                              q_clr,
    output logic [$clog2(TREE_SIZE)-1:0]      q_pos
);
    import lis_pkg::*;

    localparam int AW = $clog2(TREE_SIZE);

    logic          ent_clr_reg [2];
    logic [AW-1:0] ent_pos_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;

    logic          push, pop;
    logic [31:0]   val_ext;
    logic [31:0]   val_clamp;
    logic          in_clr;

    // Classify the item and clamp values beyond the tree to the last position.
    always_comb begin
        val_ext   = 32'(s_value);
        val_clamp = (val_ext >= 32'(TREE_SIZE)) ? 32'(TREE_SIZE - 1) : val_ext;
        in_clr    = (s_cmd == CMD_CLEAR);
    end

    // Two-entry queue handshake.
    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_clr   = ent_clr_reg[rd_ptr_reg];
    assign q_pos   = ent_pos_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    // Queue pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue entries.
    always_ff @(posedge aclk) begin
        if (push) begin
            ent_clr_reg[wr_ptr_reg] <= in_clr;
            ent_pos_reg[wr_ptr_reg] <= val_clamp[AW-1:0];
        end
    end

endmodule

// ===== rtl/core/lis_back.sv =====
// Back end: tree memory, query and update walks, clearing sweep and result register.
`timescale 1ns / 1ps

module lis_back #(
    parameter int TREE_SIZE = 1024,
    parameter int LEN_BITS  = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_valid,
    output logic                              q_ready,
    input  logic                              q_clr,
    input  logic [$clog2(TREE_SIZE)-1:0]      q_pos,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [lis_pkg::OUT_W-1:0]         m_lis_length,
    output lis_pkg::lis_stat_t                stat
);
    import lis_pkg::*;

    localparam int AW = $clog2(TREE_SIZE);
    localparam int PW = AW + 2;
    localparam int LW = (LEN_BITS < OUT_W) ? LEN_BITS : OUT_W;
    localparam logic [LW-1:0] CEIL = '1;

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_QUERY  = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_RESULT = 5'b10000
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] swp_reg, swp_next;
    logic          clr_resp_reg, clr_resp_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [AW-1:0] item_pos_reg, item_pos_next;
    logic [AW-1:0] wpos_reg, wpos_next;
    logic [LW-1:0] acc_reg, acc_next;
    logic [LW-1:0] cand_reg, cand_next;
    logic [LW-1:0] best_reg, best_next;
    logic          rd_pend_reg, rd_pend_next;
    logic          out_valid_reg, out_valid_next;
    logic [LW-1:0] out_len_reg;

    logic [LW-1:0] mem [TREE_SIZE];
    logic [LW-1:0] rdata_reg;
    logic          mem_re, mem_we;
    logic [AW-1:0] mem_raddr, mem_waddr;
    logic [LW-1:0] mem_wdata;

    logic [PW-1:0] pos_dec;
    logic [PW-1:0] pos_low;
    logic [LW-1:0] cand;
    logic          out_load;

    assign pos_dec = pos_reg - PW'(1);
    assign pos_low = pos_reg & (~pos_reg + PW'(1));
    assign cand    = (acc_reg == CEIL) ? CEIL : acc_reg + LW'(1);

    // Sequencer for the clearing sweep and the two tree walks.
    always_comb begin
        state_next    = state_reg;
        swp_next      = swp_reg;
        clr_resp_next = clr_resp_reg;
        pos_next      = pos_reg;
        item_pos_next = item_pos_reg;
        wpos_next     = wpos_reg;
        acc_next      = acc_reg;
        cand_next     = cand_reg;
        best_next     = best_reg;
        rd_pend_next  = rd_pend_reg;
        q_ready       = 1'b0;
        mem_re        = 1'b0;
        mem_raddr     = pos_dec[AW-1:0];
        mem_we        = 1'b0;
        mem_waddr     = wpos_reg;
        mem_wdata     = cand_reg;
        out_load      = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = swp_reg;
                mem_wdata = '0;
                swp_next  = swp_reg + AW'(1);
                if (swp_reg == AW'(TREE_SIZE - 1)) begin
                    state_next = clr_resp_reg ? ST_RESULT : ST_IDLE;
                end
            end
            ST_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    if (q_clr) begin
                        state_next    = ST_CLEAR;
                        swp_next      = '0;
                        clr_resp_next = 1'b1;
                        best_next     = '0;
                    end else begin
                        state_next    = ST_QUERY;
                        pos_next      = PW'(q_pos);
                        item_pos_next = q_pos;
                        acc_next      = '0;
                        rd_pend_next  = 1'b0;
                    end
                end
            end
            ST_QUERY: begin
                // Fold in the entry read last cycle, then step down the prefix.
                if (rd_pend_reg && (rdata_reg > acc_reg)) begin
                    acc_next = rdata_reg;
                end
                if (pos_reg != '0) begin
                    mem_re       = 1'b1;
                    pos_next     = pos_reg - pos_low;
                    rd_pend_next = 1'b1;
                end else begin
                    rd_pend_next = 1'b0;
                    if (!rd_pend_reg) begin
                        cand_next  = cand;
                        best_next  = (cand > best_reg) ? cand : best_reg;
                        pos_next   = PW'(item_pos_reg) + PW'(1);
                        state_next = ST_UPDATE;
                    end
                end
            end
            ST_UPDATE: begin
                // Raise the entry read last cycle while reading the next one up.
                if (rd_pend_reg && (rdata_reg < cand_reg)) begin
                    mem_we = 1'b1;
                end
                if (32'(pos_reg) <= 32'(TREE_SIZE)) begin
                    mem_re       = 1'b1;
                    wpos_next    = pos_dec[AW-1:0];
                    pos_next     = pos_reg + pos_low;
                    rd_pend_next = 1'b1;
                end else begin
                    rd_pend_next = 1'b0;
                    if (!rd_pend_reg) begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_RESULT: begin
                if (!out_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers; reset starts a clearing sweep of the tree.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            swp_reg       <= '0;
            clr_resp_reg  <= 1'b0;
            best_reg      <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            swp_reg       <= swp_next;
            clr_resp_reg  <= clr_resp_next;
            best_reg      <= best_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Walk datapath registers.
    always_ff @(posedge aclk) begin
        pos_reg      <= pos_next;
        item_pos_reg <= item_pos_next;
        wpos_reg     <= wpos_next;
        acc_reg      <= acc_next;
        cand_reg     <= cand_next;
        if (out_load) begin
            out_len_reg <= best_reg;
        end
    end

    // Tree memory with one write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_lis_length = OUT_W'(out_len_reg);

    assign stat.sweep  = (state_reg == ST_CLEAR);
    assign stat.idle   = (state_reg == ST_IDLE);
    assign stat.result = (state_reg == ST_RESULT);

endmodule

// ===== rtl/core/longest_increasing_subsequence_unit.sv =====
// Push: the item is taken from the queue, a query walk reads the prefix maxima, an update
// walk raises the entries above the item, and the result is registered in the result state.
// The walks go through the single read port of the tree memory; one transaction is worked at
// a time.
// Clear: a sweep of the whole tree, one tree entry zeroed per cycle through the write port.
// Reset (aresetn low, synchronous) starts the same sweep; two inputs queue.
`timescale 1ns / 1ps

module longest_increasing_subsequence_unit #(
    parameter int TREE_SIZE = lis_pkg::DEF_TREE_SIZE,
    parameter int LEN_BITS  = lis_pkg::DEF_LEN_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_cmd,
    input  logic [lis_pkg::VAL_W-1:0]     s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lis_pkg::OUT_W-1:0]     m_lis_length
);
    import lis_pkg::*;

    localparam int AW = $clog2(TREE_SIZE);

    logic          q_valid;
    logic          q_ready;
    logic          q_clr;
    logic [AW-1:0] q_pos;
    lis_stat_t     stat;

    // Front end with the transaction queue.
    lis_front #(
        .TREE_SIZE (TREE_SIZE)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_cmd),
        .s_value (s_value),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_clr   (q_clr),
        .q_pos   (q_pos)
    );

    // Back end with the tree memory.
    lis_back #(
        .TREE_SIZE (TREE_SIZE),
        .LEN_BITS  (LEN_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_clr        (q_clr),
        .q_pos        (q_pos),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_lis_length (m_lis_length),
        .stat         (stat)
    );

    // A result is loaded only from the result state.
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(stat.result))
        else $error("result appeared without passing the result state");

    // No result can come straight out of a clearing sweep.
    a_sweep_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.sweep |=> !$rose(m_valid))
        else $error("result appeared during the clearing sweep");

    // An idle back end takes queued work at once.
    a_idle_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (stat.idle && q_valid) |=> !stat.idle)
        else $error("back end left queued work waiting");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the longest increasing subsequence tracker.
`timescale 1ns / 1ps

module tb_top;

    import lis_pkg::*;

    localparam int NODES    = DEF_TREE_SIZE;
    localparam int LEN_W    = DEF_LEN_BITS;
    localparam int N_ITEMS  = 1900;
    localparam int HOLD_LEN = 600;
    // The length ceiling is the smaller of the tree width maximum and the output maximum.
    localparam longint LEN_MAX_L = (longint'(1) << LEN_W) - 1;
    localparam logic [OUT_W-1:0] LEN_CEIL = (LEN_MAX_L > 65535) ? 16'hFFFF : LEN_MAX_L[OUT_W-1:0];

    typedef struct {
        lis_cmd_t         cmd;
        logic [VAL_W-1:0] value;
    } lis_item_t;

    logic                aclk       = 1'b0;
    logic                aresetn    = 1'b0;
    logic                s_valid    = 1'b0;
    logic                s_ready;
    logic                s_cmd      = 1'b0;
    logic [VAL_W-1:0]    s_value    = '0;
    logic                m_valid;
    logic                m_ready    = 1'b0;
    logic [OUT_W-1:0]    m_lis_length;

    // Pending transactions and the lengths they are expected to produce.
    lis_item_t           stim_q[$];
    logic [OUT_W-1:0]    lis_expect_q[$];

    // Shadow copy of the prefix-maximum tree, indexed from one.
    logic [LEN_W-1:0]    fen_max [1:NODES];
    logic [LEN_W-1:0]    best_len;

    int unsigned         n_items      = 0;
    int unsigned         offered_cnt  = 0;
    int unsigned         accepted_cnt = 0;
    int unsigned         result_cnt   = 0;
    int unsigned         fail_cnt     = 0;
    int unsigned         hold_left    = 0;
    bit                  hold_used    = 1'b0;
    int unsigned         idle_phase;
    int unsigned         send_idle_pct;
    int unsigned         recv_idle_pct;

    longest_increasing_subsequence_unit #(
        .TREE_SIZE(NODES),
        .LEN_BITS (LEN_W)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_lis_length(m_lis_length)
    );

    // Clock generation.
    initial begin
        forever #2 aclk = ~aclk;
    end

    // Idle rates move through three phases as the input is consumed.
    assign idle_phase    = (accepted_cnt < n_items / 3) ? 0 :
                           (accepted_cnt < (2 * n_items) / 3) ? 1 : 2;
    assign send_idle_pct = (idle_phase == 0) ? 27 : (idle_phase == 1) ? 77 : 0;
    assign recv_idle_pct = (idle_phase == 0) ? 77 : (idle_phase == 1) ? 27 : 0;

    // Compute the running best length after one command, updating the shadow tree.
    function automatic void lis_track(input lis_cmd_t cmd, input logic [VAL_W-1:0] val,
                                      output logic [OUT_W-1:0] len);
        int               pos;
        int               v;
        logic [LEN_W-1:0] run;
        logic [LEN_W-1:0] cand;
        if (cmd == CMD_CLEAR) begin
            for (int i = 1; i <= NODES; i++) fen_max[i] = '0;
            best_len = '0;
            len      = '0;
        end else begin
            v = int'(val);
            if (v >= NODES) v = NODES - 1;
            // Best length over all strictly smaller values, positions 1..v.
            run = '0;
            pos = v;
            while (pos >= 1) begin
                if (fen_max[pos] > run) run = fen_max[pos];
                pos -= pos & (-pos);
            end
            cand = (run < LEN_CEIL) ? run + 1'b1 : LEN_W'(LEN_CEIL);
            // Propagate the candidate upward from the value's own position.
            pos = v + 1;
            while (pos <= NODES) begin
                if (fen_max[pos] < cand) fen_max[pos] = cand;
                pos += pos & (-pos);
            end
            if (cand > best_len) best_len = cand;
            len = OUT_W'(best_len);
        end
    endfunction

    function automatic void add_item(input lis_cmd_t cmd, input int unsigned val);
        lis_item_t it;
        it.cmd   = cmd;
        it.value = val[VAL_W-1:0];
        stim_q.push_back(it);
    endfunction

    // Driver: presents the next pending transaction at the falling edge.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || accepted_cnt == offered_cnt) begin
            if (stim_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid     <= 1'b1;
                s_cmd       <= stim_q[0].cmd;
                s_value     <= stim_q[0].value;
                offered_cnt <= offered_cnt + 1;
                void'(stim_q.pop_front());
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, so the block backs up and stalls its input.
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_used && result_cnt >= 120) begin
            hold_left <= HOLD_LEN;
            hold_used <= 1'b1;
        end
    end

    // Receiver: random back-pressure on the result channel.
    always @(negedge aclk) begin
        m_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: predicts on each accepted input and checks each accepted result.
    always @(posedge aclk) begin
        logic [OUT_W-1:0] exp_len;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                lis_track(lis_cmd_t'(s_cmd), s_value, exp_len);
                lis_expect_q.push_back(exp_len);
                accepted_cnt <= accepted_cnt + 1;
            end
            if (m_valid && m_ready) begin
                result_cnt <= result_cnt + 1;
                if (lis_expect_q.size() == 0) begin
                    fail_cnt <= fail_cnt + 1;
                    if (fail_cnt < 10)
                        $display("ERROR: unexpected result lis_length=%0d", m_lis_length);
                end else begin
                    exp_len = lis_expect_q.pop_front();
                    if (m_lis_length !== exp_len) begin
                        fail_cnt <= fail_cnt + 1;
                        if (fail_cnt < 10)
                            $display("ERROR: result %0d lis_length expected %0d, got %0d",
                                     result_cnt, exp_len, m_lis_length);
                    end
                end
            end
        end
    end

    // Stimulus, reset and end of test.
    initial begin
        int unsigned cur;
        int unsigned seg_len;
        int unsigned mode;
        int unsigned r;

        for (int i = 1; i <= NODES; i++) fen_max[i] = '0;
        best_len = '0;

        // Directed part: value extremes, equal values, clears and alternating bits.
        add_item(CMD_PUSH, 0);
        add_item(CMD_PUSH, 0);
        add_item(CMD_PUSH, 1023);
        add_item(CMD_PUSH, 1023);
        add_item(CMD_PUSH, 1);
        add_item(CMD_PUSH, 2);
        add_item(CMD_PUSH, 512);
        add_item(CMD_PUSH, 1022);
        add_item(CMD_CLEAR, 1023);
        add_item(CMD_PUSH, 1023);
        add_item(CMD_PUSH, 0);
        add_item(CMD_PUSH, 341);
        add_item(CMD_PUSH, 682);
        add_item(CMD_PUSH, 341);
        add_item(CMD_PUSH, 1023);
        add_item(CMD_CLEAR, 0);
        add_item(CMD_CLEAR, 682);
        add_item(CMD_PUSH, 5);
        add_item(CMD_PUSH, 4);
        add_item(CMD_PUSH, 3);
        add_item(CMD_PUSH, 6);
        add_item(CMD_PUSH, 7);

        // Random part: mostly runs of pushes with assorted shapes, a clear before most runs.
        while (stim_q.size() < N_ITEMS) begin
            if ($urandom_range(99) < 70) add_item(CMD_CLEAR, $urandom_range(1023));
            seg_len = ($urandom_range(9) == 0) ? $urandom_range(100, 200) : $urandom_range(10, 60);
            mode    = $urandom_range(3);
            cur     = $urandom_range(50);
            for (int k = 0; k < seg_len; k++) begin
                case (mode)
                    0: begin
                        // Mostly rising with the odd repeat or drop.
                        r = $urandom_range(9);
                        if (r < 7) begin
                            cur += $urandom_range(1, 8);
                            if (cur > 1023) cur = $urandom_range(100);
                        end else if (r == 8) begin
                            cur = $urandom_range(cur);
                        end
                        add_item(CMD_PUSH, cur);
                    end
                    1: add_item(CMD_PUSH, $urandom_range(1023));
                    2: add_item(CMD_PUSH, $urandom_range(15));
                    default: begin
                        // Crowd the top of the range, with a few low values.
                        if ($urandom_range(3) == 0) add_item(CMD_PUSH, $urandom_range(7));
                        else add_item(CMD_PUSH, $urandom_range(1000, 1023));
                    end
                endcase
            end
        end
        n_items = stim_q.size();

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (accepted_cnt != n_items || lis_expect_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);

        if (fail_cnt == 0 && lis_expect_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
